### rtl/fpaa_pkg.sv
// Shared types, codes and defaults for the fit-policy arena allocator.
`timescale 1ns / 1ps
package fpaa_pkg;

    localparam int unsigned MAX_BLOCKS_DEF   = 16;
    localparam int unsigned ARENA_BYTES_DEF  = 65536;
    localparam int unsigned HEADER_BYTES_DEF = 24;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARENA    = 1'd1;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NOFIT = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef enum logic [1:0] {
        RES_OK,
        RES_NOFIT,
        RES_FULL,
        RES_FREE
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_FIN,
        S_PREP,
        S_SHIFT,
        S_COMMIT,
        S_RESP
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic fin;
        logic shift_init;
        logic shift;
        logic commit;
        logic respond;
        t_res res;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic scan_more;
        logic rd_busy;
        logic op_free;
        logic found;
        logic shift_more;
    } t_stat;

endpackage

### rtl/fpaa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fpaa_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/fpaa_dp.sv
// Datapath: block table, scan and gap evaluation, shifting, result registers.
`timescale 1ns / 1ps
module fpaa_dp import fpaa_pkg::*; #(
    parameter int unsigned MAX_BLOCKS   = MAX_BLOCKS_DEF,
    parameter int unsigned ARENA_BYTES  = ARENA_BYTES_DEF,
    parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_opcode,
    input  logic [15:0]           i_request_bytes,
    input  logic [15:0]           i_free_offset,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output logic [15:0]           o_data_offset,
    output logic [1:0]            o_status
);

    localparam int unsigned AW      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int unsigned CW      = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned END_CAP = (ARENA_BYTES < 65536) ? ARENA_BYTES : 65536;
    localparam logic [16:0] END_MAX = 17'(END_CAP);
    localparam logic [16:0] HDR17   = 17'(HEADER_BYTES);
    localparam logic [17:0] HDR18   = 18'(HEADER_BYTES);
    localparam logic [18:0] HDR19   = 19'(HEADER_BYTES);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);

    logic [1:0]    r_fit_mode;
    logic [16:0]   r_arena;
    logic [CW-1:0] r_count;
    logic          r_op;
    logic [15:0]   r_req;
    logic [15:0]   r_off;
    logic [16:0]   r_need;
    logic [CW-1:0] r_idx;
    logic          r_rd_vld;
    logic          r_rd_shift;
    logic [CW-1:0] r_rd_addr;
    logic          r_have_prev;
    logic [17:0]   r_prev_left;
    logic [CW-1:0] r_prev_idx;
    logic          r_found;
    logic [16:0]   r_pick_gap;
    logic [15:0]   r_pick_left;
    logic [CW-1:0] r_ins;
    logic          r_match;
    logic [CW-1:0] r_match_idx;
    logic [15:0]   r_out_offset;
    logic [1:0]    r_out_status;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic          ram_re;
    logic [CW-1:0] rd_idx;
    logic [31:0]   ram_rdata;
    logic [15:0]   d_start;
    logic [15:0]   d_len;
    logic          scan_ret;
    logic [16:0]   arena_end;
    logic          ev_en;
    logic [17:0]   ev_left;
    logic [16:0]   ev_right;
    logic [CW-1:0] ev_ins;
    logic [16:0]   ev_gap;
    logic          ev_fits;
    logic          ev_better;
    logic          ev_take;
    logic          hit;
    logic [CW-1:0] wr_dest;

    // table entry: length in the upper half, header offset in the lower
    fpaa_ram #(
        .WIDTH (32),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (rd_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign d_start  = ram_rdata[15:0];
    assign d_len    = ram_rdata[31:16];
    assign scan_ret = r_rd_vld && !r_rd_shift;

    assign arena_end = (r_arena < END_MAX) ? r_arena : END_MAX;

    // inserting walks down from the top, removing walks up
    assign ram_re = i_cmd.scan || i_cmd.shift;
    assign rd_idx = (i_cmd.shift && r_op == OP_ALLOC) ? r_idx - CW'(1) : r_idx;
    assign wr_dest = (r_op == OP_FREE) ? r_rd_addr - CW'(1) : r_rd_addr + CW'(1);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = wr_dest[AW-1:0];
        ram_wdata = ram_rdata;
        if (r_rd_vld && r_rd_shift) begin
            ram_we = 1'b1;
        end else if (i_cmd.commit && r_op == OP_ALLOC) begin
            ram_we    = 1'b1;
            ram_waddr = r_ins[AW-1:0];
            ram_wdata = {r_req, r_pick_left};
        end
    end

    // gap after the previous block, up to the returned block or the arena end
    always_comb begin
        ev_en    = (scan_ret && r_op == OP_ALLOC && r_have_prev) || i_cmd.fin;
        ev_left  = r_have_prev ? r_prev_left : 18'd0;
        ev_right = i_cmd.fin ? arena_end : {1'b0, d_start};
        ev_ins   = r_have_prev ? r_prev_idx + CW'(1) : '0;
        ev_gap   = ({1'b0, ev_right} > ev_left) ? 17'({1'b0, ev_right} - ev_left) : 17'd0;
        ev_fits  = (r_need <= ev_gap) && ((19'(ev_left) + HDR19) <= 19'h0FFFF);
        ev_better = !r_found
                 || (r_fit_mode == FIT_BEST  && ev_gap < r_pick_gap)
                 || (r_fit_mode == FIT_WORST && ev_gap > r_pick_gap);
        ev_take  = ev_en && ev_fits && ev_better && (r_fit_mode <= FIT_WORST);
    end

    assign hit = scan_ret && r_op == OP_FREE && !r_match
              && ((17'(d_start) + HDR17) == {1'b0, r_off});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode <= FIT_FIRST;
            r_arena    <= 17'h10000;
            r_count    <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FIT_MODE: r_fit_mode <= i_cfg_data[1:0];
                    CFG_ARENA:    r_arena    <= i_cfg_data;
                    default:      r_arena    <= r_arena;
                endcase
            end
            r_rd_vld <= ram_re;
            if (i_cmd.commit) begin
                r_count <= (r_op == OP_FREE) ? r_count - CW'(1) : r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_shift <= i_cmd.shift;
        if (ram_re) begin
            r_rd_addr <= rd_idx;
        end
        if (i_cmd.load) begin
            r_op        <= i_opcode;
            r_req       <= i_request_bytes;
            r_off       <= i_free_offset;
            r_need      <= 17'(i_request_bytes) + HDR17;
            r_idx       <= '0;
            r_have_prev <= 1'b0;
            r_found     <= 1'b0;
            r_match     <= 1'b0;
        end else begin
            if (i_cmd.scan) begin
                r_idx <= r_idx + CW'(1);
            end else if (i_cmd.shift_init) begin
                r_idx <= (r_op == OP_FREE) ? r_match_idx + CW'(1) : r_count;
            end else if (i_cmd.shift) begin
                r_idx <= (r_op == OP_FREE) ? r_idx + CW'(1) : r_idx - CW'(1);
            end
            if (scan_ret && r_op == OP_ALLOC) begin
                r_prev_left <= 18'(d_start) + 18'(d_len) + HDR18;
                r_prev_idx  <= r_rd_addr;
                r_have_prev <= 1'b1;
            end
            if (ev_take) begin
                r_found     <= 1'b1;
                r_pick_gap  <= ev_gap;
                r_pick_left <= ev_left[15:0];
                r_ins       <= ev_ins;
            end
            if (hit) begin
                r_match     <= 1'b1;
                r_match_idx <= r_rd_addr;
            end
        end
        if (i_cmd.respond) begin
            case (i_cmd.res)
                RES_OK: begin
                    r_out_offset <= 16'(17'(r_pick_left) + HDR17);
                    r_out_status <= STAT_OK;
                end
                RES_NOFIT: begin
                    r_out_offset <= '0;
                    r_out_status <= STAT_NOFIT;
                end
                RES_FULL: begin
                    r_out_offset <= '0;
                    r_out_status <= STAT_FULL;
                end
                default: begin
                    r_out_offset <= '0;
                    r_out_status <= STAT_OK;
                end
            endcase
        end
    end

    always_comb begin
        o_stat.full       = (r_count == CNT_MAX);
        o_stat.scan_more  = (r_idx < r_count);
        o_stat.rd_busy    = r_rd_vld;
        o_stat.op_free    = (r_op == OP_FREE);
        o_stat.found      = (r_op == OP_FREE) ? r_match : r_found;
        o_stat.shift_more = (r_op == OP_FREE) ? (r_idx < r_count) : (r_idx > r_ins);
    end

    assign o_data_offset = r_out_offset;
    assign o_status      = r_out_status;

endmodule

### rtl/fpaa_ctrl.sv
// Controller: sequences scan, placement, shifting and the result transfer.
`timescale 1ns / 1ps
module fpaa_ctrl import fpaa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    output logic  o_m_tvalid,
    input  logic  i_m_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    t_res   r_res, n_res;
    logic   r_out_vld, n_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_res     <= RES_OK;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_res     <= n_res;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_res      = r_res;
        n_out_vld  = r_out_vld && !i_m_tready;
        o_cmd      = '0;
        o_cmd.res  = r_res;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_stat.op_free && i_stat.full) begin
                    n_res   = RES_FULL;
                    n_state = S_RESP;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_more) begin
                    o_cmd.scan = 1'b1;
                end else if (!i_stat.rd_busy) begin
                    n_state = i_stat.op_free ? S_PREP : S_FIN;
                end
            end
            S_FIN: begin
                // last gap runs to the arena end; empty table lands here too
                o_cmd.fin = 1'b1;
                n_state   = S_PREP;
            end
            S_PREP: begin
                if (i_stat.found) begin
                    o_cmd.shift_init = 1'b1;
                    n_state          = S_SHIFT;
                end else begin
                    n_res   = i_stat.op_free ? RES_FREE : RES_NOFIT;
                    n_state = S_RESP;
                end
            end
            S_SHIFT: begin
                if (i_stat.shift_more) begin
                    o_cmd.shift = 1'b1;
                end else if (!i_stat.rd_busy) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_res        = i_stat.op_free ? RES_FREE : RES_OK;
                n_state      = S_RESP;
            end
            S_RESP: begin
                if (!r_out_vld || i_m_tready) begin
                    o_cmd.respond = 1'b1;
                    n_out_vld     = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_out_vld;

endmodule

### rtl/fit_policy_arena_allocator_top.sv
// Top level of the fit-policy arena allocator.
//
//  channel  direction  handshake                  payload
//  s        in         i_s_tvalid / o_s_tready    tuser opcode, tdata request/offset
//  m        out        o_m_tvalid / i_m_tready    tuser status, tdata data_offset
//  cfg      in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One request at a time. Scanning the table entries and moving them both read through
// the table RAM's single read port, one entry after another. A failed search skips the
// move and commit, and a full table goes from the check straight to the response. The
// result register holds its transfer while the next request is taken. Reset empties the
// table, no clearing.
`timescale 1ns / 1ps
module fit_policy_arena_allocator_top import fpaa_pkg::*; #(
    parameter int unsigned MAX_BLOCKS   = MAX_BLOCKS_DEF,
    parameter int unsigned ARENA_BYTES  = ARENA_BYTES_DEF,
    parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [31:0]           i_s_tdata,   // [15:0] request_bytes, [31:16] free_offset
    input  logic                  i_s_tuser,   // [0] opcode
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [15:0]           o_m_tdata,   // [15:0] data_offset
    output logic [1:0]            o_m_tuser,   // [1:0] status
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    fpaa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fpaa_dp #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .ARENA_BYTES  (ARENA_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_opcode        (i_s_tuser),
        .i_request_bytes (i_s_tdata[15:0]),
        .i_free_offset   (i_s_tdata[31:16]),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_data_offset   (o_m_tdata),
        .o_status        (o_m_tuser)
    );

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.scan, cmd.fin, cmd.shift_init, cmd.shift,
                  cmd.commit, cmd.respond}))
        else $error("more than one datapath command at once");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request taken while another is in progress");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.scan |-> stat.scan_more)
        else $error("table read beyond the valid entries");

    a_respond_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.respond |=> o_m_tvalid)
        else $error("result loaded without raising valid");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.respond |-> (!o_m_tvalid || i_m_tready))
        else $error("result register overwritten before transfer");

endmodule

### tb/fit_policy_arena_allocator_checker.sv
// Scoreboard for the arena allocator: mirrors the block table and checks every response.
`timescale 1ns / 1ps
module fit_policy_arena_allocator_checker import fpaa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [31:0]           i_s_tdata,   // [15:0] request_bytes, [31:16] free_offset
    input  logic                  i_s_tuser,   // [0] opcode
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [15:0]           i_m_tdata,   // [15:0] data_offset
    input  logic [1:0]            i_m_tuser,   // [1:0] status
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_outstanding,
    output int                    o_fail_count,
    output int                    o_granted,
    output int                    o_no_space,
    output int                    o_table_full
);

    localparam int HDR   = HEADER_BYTES_DEF;
    localparam int SLOTS = MAX_BLOCKS_DEF;

    typedef struct packed {
        logic [15:0] data_offset;
        logic [1:0]  status;
    } t_grant;

    logic [1:0]  fit_sel;
    logic [16:0] arena_sz;
    logic [15:0] blk_start [SLOTS];
    logic [15:0] blk_len   [SLOTS];
    logic [4:0]  blk_cnt;
    t_grant      grant_q [$];
    t_grant      due;
    int          errs;
    int          n_ok;
    int          n_nofit;
    int          n_full;

    // a placement needs the room and a data offset that still fits in 16 bits
    function automatic bit gap_fits(input int left, input int right, input int need);
        int gap;
        gap = (right > left) ? right - left : 0;
        return (need <= gap) && (left + HDR <= 65535);
    endfunction

    // applies one request to the mirrored table and returns the response it should give
    function automatic t_grant serve_request(input logic op, input logic [15:0] req,
                                             input logic [15:0] off);
        int     need;
        int     lim;
        int     left;
        int     right;
        int     gap;
        int     pick;
        int     pick_gap;
        int     pick_left;
        int     hit;
        bit     found;
        bit     take;
        t_grant g;
        g.data_offset = '0;
        g.status      = STAT_OK;
        if (op == OP_FREE) begin
            hit = -1;
            for (int i = 0; i < blk_cnt; i++)
                if (hit < 0 && int'(blk_start[i]) + HDR == int'(off))
                    hit = i;
            if (hit >= 0) begin
                for (int j = hit; j + 1 < blk_cnt; j++) begin
                    blk_start[j] = blk_start[j + 1];
                    blk_len[j]   = blk_len[j + 1];
                end
                blk_cnt = blk_cnt - 5'd1;
            end
            return g;
        end
        if (blk_cnt >= SLOTS) begin
            g.status = STAT_FULL;
            return g;
        end
        need = int'(req) + HDR;
        lim  = int'(arena_sz);
        if (lim > int'(ARENA_BYTES_DEF))
            lim = int'(ARENA_BYTES_DEF);
        if (lim > 65536)
            lim = 65536;
        if (blk_cnt == 0) begin
            if (fit_sel <= FIT_WORST && gap_fits(0, lim, need)) begin
                blk_start[0]  = '0;
                blk_len[0]    = req;
                blk_cnt       = 5'd1;
                g.data_offset = 16'(HDR);
            end else begin
                g.status = STAT_NOFIT;
            end
            return g;
        end
        // the gap in front of the first block is never offered
        found     = 1'b0;
        pick      = 0;
        pick_gap  = 0;
        pick_left = 0;
        for (int i = 0; i < blk_cnt && fit_sel <= FIT_WORST; i++) begin
            left  = int'(blk_start[i]) + HDR + int'(blk_len[i]);
            right = (i + 1 < blk_cnt) ? int'(blk_start[i + 1]) : lim;
            gap   = (right > left) ? right - left : 0;
            if (gap_fits(left, right, need)) begin
                if (!found)
                    take = 1'b1;
                else if (fit_sel == FIT_BEST)
                    take = gap < pick_gap;
                else if (fit_sel == FIT_WORST)
                    take = gap > pick_gap;
                else
                    take = 1'b0;
                if (take) begin
                    found     = 1'b1;
                    pick      = i;
                    pick_gap  = gap;
                    pick_left = left;
                end
                if (found && fit_sel == FIT_FIRST)
                    break;
            end
        end
        if (!found) begin
            g.status = STAT_NOFIT;
            return g;
        end
        for (int i = blk_cnt; i > pick + 1; i--) begin
            blk_start[i] = blk_start[i - 1];
            blk_len[i]   = blk_len[i - 1];
        end
        blk_start[pick + 1] = 16'(pick_left);
        blk_len[pick + 1]   = req;
        blk_cnt             = blk_cnt + 5'd1;
        g.data_offset       = 16'(pick_left + HDR);
        return g;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fit_sel  = FIT_FIRST;
            arena_sz = 17'(ARENA_BYTES_DEF);
            blk_cnt  = '0;
            grant_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_FIT_MODE)
                    fit_sel = i_cfg_data[1:0];
                else if (i_cfg_index == CFG_ARENA)
                    arena_sz = i_cfg_data;
            end
            // response side first: a result never belongs to a request taken on the same edge
            if (i_m_tvalid && i_m_tready) begin
                case (i_m_tuser)
                    STAT_OK:    n_ok++;
                    STAT_NOFIT: n_nofit++;
                    STAT_FULL:  n_full++;
                    default: ;
                endcase
                if (grant_q.size() == 0) begin
                    errs++;
                    $error("unexpected transfer: data_offset %0d status %0d",
                           i_m_tdata, i_m_tuser);
                end else begin
                    due = grant_q.pop_front();
                    if (i_m_tdata !== due.data_offset) begin
                        errs++;
                        $error("data_offset: expected %0d, got %0d",
                               due.data_offset, i_m_tdata);
                    end
                    if (i_m_tuser !== due.status) begin
                        errs++;
                        $error("status: expected %0d, got %0d", due.status, i_m_tuser);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                grant_q.push_back(serve_request(i_s_tuser, i_s_tdata[15:0],
                                                i_s_tdata[31:16]));
        end
        o_outstanding <= grant_q.size();
        o_fail_count  <= errs;
        o_granted     <= n_ok;
        o_no_space    <= n_nofit;
        o_table_full  <= n_full;
    end

endmodule

### tb/fit_policy_arena_allocator_top_tb.sv
// Testbench top: directed and random allocate/free traffic under changing policies and arena sizes.
`timescale 1ns / 1ps
module fit_policy_arena_allocator_top_tb;
    import fpaa_pkg::*;

    localparam logic [1:0] FIT_NONE    = 2'd3;
    localparam int         CHUNKS      = 10;
    localparam int         CHUNK_ITEMS = 150;
    localparam int         SETTLE      = 64;
    localparam int         TIMEOUT     = 1_000_000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int outstanding;
    int fail_count;
    int n_granted;
    int n_no_space;
    int n_table_full;

    int          cycles      = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          n_alloc     = 0;
    int          n_free      = 0;
    logic [15:0] live_q [$];

    fit_policy_arena_allocator_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    fit_policy_arena_allocator_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_outstanding (outstanding),
        .o_fail_count  (fail_count),
        .o_granted     (n_granted),
        .o_no_space    (n_no_space),
        .o_table_full  (n_table_full)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // offsets handed out and not yet released; frees are drawn from here
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready && m_tuser == STAT_OK && m_tdata != 16'd0)
            live_q.push_back(m_tdata);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= TIMEOUT) begin
            $display("fit_policy_arena_allocator_top_tb: FAIL");
            $finish;
        end
    end

    task automatic put_request(input logic op, input logic [15:0] req, input logic [15:0] off);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {off, req};
        do @(posedge clk); while (!s_tready);
        if (op == OP_FREE) begin
            n_free++;
            for (int i = 0; i < live_q.size(); i++)
                if (live_q[i] == off) begin
                    live_q.delete(i);
                    break;
                end
        end else begin
            n_alloc++;
        end
    endtask

    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        int unsigned roll;
        int          idx;
        logic [15:0] req;
        logic [16:0] arena;
        logic [1:0]  mode;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_idle_pct = 23;
        rx_idle_pct <= 73;

        // reset settings: first fit over the full arena
        put_request(OP_FREE, 16'hFFFF, 16'd0);          // stray free on an empty table
        put_request(OP_ALLOC, 16'hFFFF, 16'($urandom));  // larger than the arena
        put_request(OP_ALLOC, 16'd65464, 16'($urandom));
        put_request(OP_ALLOC, 16'd0, 16'($urandom));
        put_request(OP_ALLOC, 16'd0, 16'($urandom));     // room left but offset would pass 65535
        wait_until_drained();
        put_request(OP_FREE, 16'($urandom), 16'd24);
        put_request(OP_FREE, 16'($urandom), 16'd65512);
        put_request(OP_FREE, 16'($urandom), 16'hFFFF);
        for (int k = 0; k < MAX_BLOCKS_DEF; k++)
            put_request(OP_ALLOC, 16'(k * 8), 16'($urandom));
        put_request(OP_ALLOC, 16'd1, 16'($urandom));     // table full
        wait_until_drained();
        put_request(OP_FREE, 16'($urandom), 16'd24);
        wait_until_drained();
        write_reg(CFG_FIT_MODE, 17'(FIT_NONE));
        put_request(OP_ALLOC, 16'd100, 16'($urandom));
        wait_until_drained();
        write_reg(CFG_FIT_MODE, 17'(FIT_FIRST));
        write_reg(CFG_ARENA, 17'd0);                     // arena now ends before the blocks
        put_request(OP_ALLOC, 16'd0, 16'($urandom));

        for (int c = 0; c < CHUNKS; c++) begin
            wait_until_drained();
            if (c == 4) begin
                tx_idle_pct = 73;
                rx_idle_pct <= 23;
            end else if (c == 7) begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end
            mode = (c == 3) ? FIT_NONE : 2'(c % 3);
            case (c)
                1, 6:    arena = 17'h1FFFF;
                2:       arena = 17'd8192;
                3:       arena = 17'd0;
                5, 8:    arena = 17'($urandom_range(1024, 65536));
                9:       arena = 17'd65535;
                default: arena = 17'd65536;
            endcase
            write_reg(CFG_FIT_MODE, 17'(mode));
            write_reg(CFG_ARENA, arena);
            for (int k = 0; k < CHUNK_ITEMS; k++) begin
                roll = $urandom_range(99);
                if (live_q.size() != 0 && roll < ((live_q.size() >= 14) ? 55 : 35)) begin
                    idx = $urandom_range(live_q.size() - 1);
                    put_request(OP_FREE, 16'($urandom), live_q[idx]);
                end else if (roll >= 95) begin
                    put_request(OP_FREE, 16'($urandom), 16'($urandom));
                end else begin
                    case ($urandom_range(19))
                        0:          req = 16'hFFFF;
                        1:          req = 16'd0;
                        2, 3:       req = 16'($urandom);
                        4, 5, 6, 7: req = 16'($urandom_range(1024, 12000));
                        default:    req = 16'($urandom_range(0, 1023));
                    endcase
                    put_request(OP_ALLOC, req, 16'($urandom));
                end
            end
        end

        wait_until_drained();
        repeat (SETTLE) @(posedge clk);
        $display("%0d requests (%0d allocations, %0d frees) under first, best, worst and",
                 n_alloc + n_free, n_alloc, n_free);
        $display("  invalid policy, arenas 0..131071; %0d ok, %0d no space, %0d table full",
                 n_granted, n_no_space, n_table_full);
        if (fail_count == 0)
            $display("fit_policy_arena_allocator_top_tb: PASS");
        else
            $display("fit_policy_arena_allocator_top_tb: FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/fpaa_pkg.sv
rtl/fpaa_ram.sv
rtl/fpaa_dp.sv
rtl/fpaa_ctrl.sv
rtl/fit_policy_arena_allocator_top.sv
tb/fit_policy_arena_allocator_checker.sv
tb/fit_policy_arena_allocator_top_tb.sv
